/* design/radix_trie_tag_map_core_macros.svh */
// Assertion macros shared by the tag map RTL.
`ifndef RADIX_TRIE_TAG_MAP_CORE_MACROS_SVH
`define RADIX_TRIE_TAG_MAP_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define RTM_CHECK_NOW(lbl, ante, cons) \
lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
else $error("tag map check failed");
`define RTM_CHECK_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
else $error("tag map check failed");
`else
`define RTM_CHECK_NOW(lbl, ante, cons)
`define RTM_CHECK_NEXT(lbl, ante, cons)
`endif
`endif

/* design/rtm_pkg.sv */
// Constants, types and helper functions of the radix trie tag map.
package rtm_pkg;
   localparam int TAG_BITS   = 16;
   localparam int LEVEL_BITS = 4;
   localparam int NODE_POOL  = 64;
   localparam int ENTRY_BITS = 32;
   localparam int LEVELS     = (TAG_BITS + LEVEL_BITS - 1) / LEVEL_BITS;
   localparam int FANOUT     = 1 << LEVEL_BITS;
   localparam int PAD_W      = LEVELS * LEVEL_BITS;
   localparam int NODE_W     = $clog2(NODE_POOL);
   localparam int SLOT_W     = NODE_W + LEVEL_BITS;
   localparam int SLOTS      = NODE_POOL * FANOUT;
   localparam int CNT_W      = $clog2(FANOUT + 1);
   localparam int FREE_W     = $clog2(NODE_POOL + 1);
   localparam int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int OP_W       = 2;
   localparam int ST_W       = 2;

   typedef enum logic [OP_W-1:0] {
      OP_SEARCH = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_FOUND      = 2'd0,
      ST_ABSENT     = 2'd1,
      ST_POOL_EMPTY = 2'd2,
      ST_ZERO_VALUE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_START, S_WALK_RD, S_WALK_DATA, S_BUILD, S_LEAF_NEW,
      S_CNT_RD, S_CNT_DATA, S_UNW_RD, S_UNW_DATA, S_DONE
   } state_type;

   typedef logic [NODE_W-1:0] node_type;
   typedef logic [LVL_W-1:0]  lvl_type;

   typedef struct packed {
      logic     alloc;
      logic     release_en;
      node_type rel_node;
   } pool_ctl_type;

   typedef struct packed {
      node_type          lowest;
      logic [FREE_W-1:0] free_cnt;
   } pool_stat_type;

   // Child index of a tag at one level; the tag is padded with zeros at its low end.
   function automatic logic [LEVEL_BITS-1:0] level_index(logic [TAG_BITS-1:0] tag,
                                                         lvl_type lvl);
      logic [PAD_W-1:0] padded;
      padded = PAD_W'(tag) << (PAD_W - TAG_BITS);
      return padded[(LEVELS - 1 - int'(lvl)) * LEVEL_BITS +: LEVEL_BITS];
   endfunction

   function automatic node_type lowest_free(logic [NODE_POOL-1:0] map);
      node_type r;
      r = '0;
      for (int i = NODE_POOL - 1; i >= 0; i--) begin
         if (map[i]) r = NODE_W'(i);
      end
      return r;
   endfunction
endpackage

/* design/rtm_if.sv */
// Request and response channel interfaces of the tag map.
interface rtm_req_if;
   import rtm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [OP_W-1:0]       operation;
   logic [TAG_BITS-1:0]   tag;
   logic [ENTRY_BITS-1:0] entry_value;
   modport source (output valid, operation, tag, entry_value, input ready);
   modport sink (input valid, operation, tag, entry_value, output ready);
endinterface

interface rtm_rsp_if;
   import rtm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [ST_W-1:0]       status;
   logic [ENTRY_BITS-1:0] old_value;
   modport source (output valid, status, old_value, input ready);
   modport sink (input valid, status, old_value, output ready);
endinterface

/* design/radix_trie_tag_map_core.sv */
// Radix trie tag map: sequencer over the slot and used-count memories.
//
//  channel   | dir | beat contents
//  req_chan  | in  | operation, tag, entry_value
//  rsp_chan  | out | status, old_value
//
// One item at a time. Each trie level costs one slot memory read; each used-count
// update is a read-modify-write of the count memory.
// After reset a clearing pass writes all 1024 slots (and the counts); no request beat
// is taken then. A result waits in the output register while the next request beat
// is accepted; a stalled response holds the sequencer in its last step.
`include "radix_trie_tag_map_core_macros.svh"
module radix_trie_tag_map_core (
   input logic      clock,
   input logic      reset,
   rtm_req_if.sink  req_chan,
   rtm_rsp_if.source rsp_chan
);
   import rtm_pkg::*;

   state_type             state_ff, state_in;
   op_type                op_ff, op_in;
   logic [TAG_BITS-1:0]   tag_ff, tag_in;
   logic [ENTRY_BITS-1:0] val_ff, val_in;
   lvl_type               lvl_ff, lvl_in;
   node_type              path_ff [LEVELS];
   node_type              path_in [LEVELS];
   logic [NODE_W:0]       root_ff, root_in;
   status_type            status_ff, status_in;
   logic [ENTRY_BITS-1:0] old_ff, old_in;
   node_type              cnt_node_ff, cnt_node_in;
   logic                  leaf_done_ff, leaf_done_in;
   logic [SLOT_W-1:0]     clr_ff, clr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ST_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [ENTRY_BITS-1:0] rsp_old_ff, rsp_old_in;

   logic                  slot_we;
   logic [SLOT_W-1:0]     slot_waddr, slot_raddr;
   logic [ENTRY_BITS-1:0] slot_wdata, slot_rdata;
   logic                  cnt_we;
   node_type              cnt_waddr, cnt_raddr;
   logic [CNT_W-1:0]      cnt_wdata, cnt_rdata, cnt_dec;
   logic [SLOT_W-1:0]     cur_slot;
   lvl_type               last_lvl;

   pool_ctl_type          pool_ctl;
   pool_stat_type         pool_stat;

   rtm_ram #(.Width(ENTRY_BITS), .Depth(SLOTS)) u_slots (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (slot_raddr),
      .rd_data (slot_rdata)
   );

   rtm_ram #(.Width(CNT_W), .Depth(NODE_POOL)) u_counts (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   rtm_pool u_pool (
      .clock (clock),
      .reset (reset),
      .ctl   (pool_ctl),
      .stat  (pool_stat)
   );

   assign last_lvl = LVL_W'(LEVELS - 1);
   assign cur_slot = {path_ff[lvl_ff], level_index(tag_ff, lvl_ff)};
   assign cnt_dec  = (cnt_rdata != '0) ? cnt_rdata - CNT_W'(1) : '0;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      tag_in        = tag_ff;
      val_in        = val_ff;
      lvl_in        = lvl_ff;
      path_in       = path_ff;
      root_in       = root_ff;
      status_in     = status_ff;
      old_in        = old_ff;
      cnt_node_in   = cnt_node_ff;
      leaf_done_in  = leaf_done_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_old_in    = rsp_old_ff;
      slot_we       = 1'b0;
      slot_waddr    = cur_slot;
      slot_wdata    = '0;
      slot_raddr    = cur_slot;
      cnt_we        = 1'b0;
      cnt_waddr     = cnt_node_ff;
      cnt_wdata     = '0;
      cnt_raddr     = cnt_node_ff;
      pool_ctl      = '0;
      req_chan.ready = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            slot_we    = 1'b1;
            slot_waddr = clr_ff;
            cnt_we     = (clr_ff[SLOT_W-1:NODE_W] == '0);
            cnt_waddr  = clr_ff[NODE_W-1:0];
            clr_in     = clr_ff + SLOT_W'(1);
            if (&clr_ff) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               op_in    = op_type'(req_chan.operation);
               tag_in   = req_chan.tag;
               val_in   = req_chan.entry_value;
               state_in = S_START;
            end
         end
         S_START: begin
            lvl_in       = '0;
            leaf_done_in = 1'b0;
            old_in       = '0;
            status_in    = ST_ABSENT;
            path_in[0]   = NODE_W'(root_ff - (NODE_W+1)'(1));
            case (op_ff)
               OP_SEARCH, OP_REMOVE: begin
                  state_in = (root_ff == '0) ? S_DONE : S_WALK_RD;
               end
               OP_INSERT: begin
                  if (val_ff == '0) begin
                     status_in = ST_ZERO_VALUE;
                     state_in  = S_DONE;
                  end else if (root_ff != '0) begin
                     state_in = S_WALK_RD;
                  end else if (pool_stat.free_cnt < FREE_W'(LEVELS)) begin
                     status_in = ST_POOL_EMPTY;
                     state_in  = S_DONE;
                  end else begin
                     pool_ctl.alloc = 1'b1;
                     root_in        = {1'b0, pool_stat.lowest} + (NODE_W+1)'(1);
                     path_in[0]     = pool_stat.lowest;
                     state_in       = (LEVELS > 1) ? S_BUILD : S_LEAF_NEW;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_WALK_RD: begin
            state_in = S_WALK_DATA;
         end
         S_WALK_DATA: begin
            if (lvl_ff != last_lvl) begin
               if (slot_rdata != '0) begin
                  path_in[lvl_ff + LVL_W'(1)] = NODE_W'(slot_rdata - ENTRY_BITS'(1));
                  lvl_in   = lvl_ff + LVL_W'(1);
                  state_in = S_WALK_RD;
               end else if (op_ff == OP_INSERT) begin
                  // Nodes below this level are missing and must all fit in the pool.
                  if (pool_stat.free_cnt < FREE_W'(LEVELS - 1) - FREE_W'(lvl_ff)) begin
                     status_in = ST_POOL_EMPTY;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_BUILD;
                  end
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               old_in    = slot_rdata;
               status_in = (slot_rdata != '0) ? ST_FOUND : ST_ABSENT;
               state_in  = S_DONE;
               case (op_ff)
                  OP_INSERT: begin
                     slot_we    = 1'b1;
                     slot_wdata = val_ff;
                     if (slot_rdata == '0) begin
                        cnt_node_in  = path_ff[lvl_ff];
                        leaf_done_in = 1'b1;
                        state_in     = S_CNT_RD;
                     end
                  end
                  OP_REMOVE: begin
                     if (slot_rdata != '0) begin
                        slot_we  = 1'b1;
                        state_in = S_UNW_RD;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_BUILD: begin
            pool_ctl.alloc = 1'b1;
            slot_we        = 1'b1;
            slot_wdata     = ENTRY_BITS'(pool_stat.lowest) + ENTRY_BITS'(1);
            path_in[lvl_ff + LVL_W'(1)] = pool_stat.lowest;
            cnt_node_in    = path_ff[lvl_ff];
            lvl_in         = lvl_ff + LVL_W'(1);
            state_in       = S_CNT_RD;
         end
         S_LEAF_NEW: begin
            slot_we      = 1'b1;
            slot_wdata   = val_ff;
            status_in    = ST_ABSENT;
            old_in       = '0;
            cnt_node_in  = path_ff[lvl_ff];
            leaf_done_in = 1'b1;
            state_in     = S_CNT_RD;
         end
         S_CNT_RD: begin
            state_in = S_CNT_DATA;
         end
         S_CNT_DATA: begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_rdata + CNT_W'(1);
            if (leaf_done_ff) state_in = S_DONE;
            else if (lvl_ff == last_lvl) state_in = S_LEAF_NEW;
            else state_in = S_BUILD;
         end
         S_UNW_RD: begin
            cnt_raddr = path_ff[lvl_ff];
            state_in  = S_UNW_DATA;
         end
         S_UNW_DATA: begin
            cnt_we    = 1'b1;
            cnt_waddr = path_ff[lvl_ff];
            cnt_wdata = cnt_dec;
            if (cnt_dec != '0) begin
               state_in = S_DONE;
            end else begin
               // An emptied node already holds only empty slots; unlink it and free it.
               pool_ctl.release_en = 1'b1;
               pool_ctl.rel_node   = path_ff[lvl_ff];
               if (lvl_ff != '0) begin
                  slot_we    = 1'b1;
                  slot_waddr = {path_ff[lvl_ff - LVL_W'(1)],
                                level_index(tag_ff, lvl_ff - LVL_W'(1))};
                  lvl_in     = lvl_ff - LVL_W'(1);
                  state_in   = S_UNW_RD;
               end else begin
                  root_in  = '0;
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_old_in    = old_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         root_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         root_ff      <= root_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      tag_ff        <= tag_in;
      val_ff        <= val_in;
      lvl_ff        <= lvl_in;
      path_ff       <= path_in;
      status_ff     <= status_in;
      old_ff        <= old_in;
      cnt_node_ff   <= cnt_node_in;
      leaf_done_ff  <= leaf_done_in;
      rsp_status_ff <= rsp_status_in;
      rsp_old_ff    <= rsp_old_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.old_value = rsp_old_ff;

   `RTM_CHECK_NOW(a_clear_blocks_req, state_ff == S_CLEAR, !req_chan.ready)
   `RTM_CHECK_NOW(a_alloc_has_node, pool_ctl.alloc, pool_stat.free_cnt != '0)
   `RTM_CHECK_NOW(a_empty_trie_all_free, state_ff == S_IDLE && root_ff == '0, pool_stat.free_cnt == FREE_W'(NODE_POOL))
   `RTM_CHECK_NEXT(a_rsp_loaded, state_ff == S_DONE && (!rsp_valid_ff || rsp_chan.ready), rsp_chan.valid && rsp_chan.status == $past(status_ff))
endmodule

/* design/rtm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rtm_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* design/rtm_pool.sv */
// Node pool: free map, free count and lowest free node.
module rtm_pool (
   input  logic                   clock,
   input  logic                   reset,
   input  rtm_pkg::pool_ctl_type  ctl,
   output rtm_pkg::pool_stat_type stat
);
   import rtm_pkg::*;

   logic [NODE_POOL-1:0] free_map_ff, free_map_in;
   logic [FREE_W-1:0]    free_cnt_ff, free_cnt_in;

   always_comb begin
      free_map_in = free_map_ff;
      free_cnt_in = free_cnt_ff;
      if (ctl.alloc) begin
         free_map_in[lowest_free(free_map_ff)] = 1'b0;
         free_cnt_in = free_cnt_ff - FREE_W'(1);
      end else if (ctl.release_en) begin
         free_map_in[ctl.rel_node] = 1'b1;
         free_cnt_in = free_cnt_ff + FREE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_map_ff <= '1;
         free_cnt_ff <= FREE_W'(NODE_POOL);
      end else begin
         free_map_ff <= free_map_in;
         free_cnt_ff <= free_cnt_in;
      end
   end

   assign stat.lowest   = lowest_free(free_map_ff);
   assign stat.free_cnt = free_cnt_ff;
endmodule
